// ===== rtl/fcs_pkg.sv =====
`timescale 1ns / 1ps

package fcs_pkg;

	// stack geometry
	localparam int STACK_DEPTH = 128;
	localparam int WORD_BITS   = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int PTR_W       = $clog2(STACK_DEPTH + 1);

	// fixed field widths
	localparam int CAP_W   = 8;
	localparam int LC_W    = 8;
	localparam int BELOW_W = 7;
	localparam int VAR_W   = 7;
	localparam int DEPTH_W = 8;
	localparam int CNT_W   = (LC_W > BELOW_W) ? LC_W : BELOW_W;

	// widths for the capacity sum and the local slot
	localparam int SUM_W  = ((PTR_W > LC_W) ? PTR_W : LC_W) + 2;
	localparam int SLOT_W = ((PTR_W > VAR_W) ? PTR_W : VAR_W) + 1;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(100);

	typedef enum logic [2:0] {
		OP_PUSH      = 3'd0,
		OP_POP       = 3'd1,
		OP_TOP       = 3'd2,
		OP_NEW_FRAME = 3'd3,
		OP_END_FRAME = 3'd4,
		OP_GET_LOCAL = 3'd5,
		OP_SET_LOCAL = 3'd6,
		OP_DEPTH     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_FILL,
		S_WALK,
		S_WALKW,
		S_RDW,
		S_ENDW,
		S_RESP
	} state_t;

	typedef struct packed {
		op_t                req_type;
		logic [31:0]        value;
		logic [LC_W-1:0]    local_count;
		logic [BELOW_W-1:0] frames_below;
		logic [VAR_W-1:0]   var_number;
	} req_t;

	typedef struct packed {
		logic [31:0]        data;
		logic [DEPTH_W-1:0] depth;
		status_t            status;
	} rsp_t;

	typedef struct packed {
		logic                 we;
		logic                 re;
		logic [ADDR_W-1:0]    addr;
		logic [WORD_BITS-1:0] wdata;
	} mem_cmd_t;

	// a frame link is usable when it points into the live part of the stack
	function automatic logic frame_ok(input logic [WORD_BITS-1:0] f,
		input logic [PTR_W-1:0] sp);
		frame_ok = (f != '0) && (f <= WORD_BITS'(sp));
	endfunction

endpackage

// ===== rtl/fcs_ram.sv =====
`timescale 1ns / 1ps

module fcs_ram
	import fcs_pkg::*;
(
	input  logic                 clk,
	input  mem_cmd_t             cmd,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [STACK_DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.addr] <= cmd.wdata;
		end
		if (cmd.re) begin
			rdata <= mem[cmd.addr];
		end
	end

endmodule

// ===== rtl/fcs_cfg.sv =====
`timescale 1ns / 1ps

module fcs_cfg
	import fcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [CAP_W-1:0]   capacity
);

	logic [CAP_W-1:0] cap_q;
	logic             reg_hit;

	assign reg_hit  = (paddr[PADDR_W-1:2] == REG_CAPACITY);
	assign pready   = 1'b1;
	assign capacity = cap_q;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (reg_hit) begin
			prdata = PDATA_W'(cap_q);
		end
	end

endmodule

// ===== rtl/fcs_ctrl.sv =====
`timescale 1ns / 1ps

module fcs_ctrl
	import fcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CAP_W-1:0]     capacity,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  req_t                 in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rsp_t                 out_word,
	output mem_cmd_t             mem_cmd,
	input  logic [WORD_BITS-1:0] mem_rdata
);

	state_t state_q, state_d;
	req_t   req_q;

	logic [PTR_W-1:0]     sp_q, sp_d;
	logic [WORD_BITS-1:0] fp_q, fp_d;
	logic [WORD_BITS-1:0] link_q, link_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [WORD_BITS-1:0] res_data_q, res_data_d;
	status_t              res_status_q, res_status_d;
	logic                 out_valid_q;
	rsp_t                 out_word_q;

	logic [SUM_W-1:0]  cap_wide, cap_eff, nf_need;
	logic [SLOT_W-1:0] slot;
	logic              push_full, nf_over, stack_empty, fp_good, link_good;
	logic              slot_ok, walk_done, out_free, accept;

	// effective capacity and the checks made before an operation
	assign cap_wide    = SUM_W'(capacity);
	assign cap_eff     = (cap_wide > SUM_W'(STACK_DEPTH)) ? SUM_W'(STACK_DEPTH) : cap_wide;
	assign push_full   = SUM_W'(sp_q) >= cap_eff;
	assign nf_need     = SUM_W'(sp_q) + SUM_W'(1) + SUM_W'(req_q.local_count);
	assign nf_over     = nf_need > cap_eff;
	assign stack_empty = (sp_q == '0);
	assign fp_good     = frame_ok(fp_q, sp_q);

	// link walk and local slot
	assign link_good = frame_ok(link_q, sp_q);
	assign walk_done = (cnt_q == '0);
	assign slot      = SLOT_W'(link_q[PTR_W-1:0]) + SLOT_W'(req_q.var_number) - SLOT_W'(1);
	assign slot_ok   = link_good && (slot < SLOT_W'(sp_q));

	assign out_free = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (req_q.req_type)
					OP_POP, OP_TOP: state_d = stack_empty ? S_RESP : S_RDW;
					OP_NEW_FRAME: begin
						state_d = (nf_over || req_q.local_count == '0) ? S_RESP : S_FILL;
					end
					OP_END_FRAME: state_d = fp_good ? S_ENDW : S_RESP;
					OP_GET_LOCAL, OP_SET_LOCAL: begin
						state_d = (req_q.var_number == '0) ? S_RESP : S_WALK;
					end
					default: state_d = S_RESP;
				endcase
			end
			S_FILL: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = S_RESP;
				end
			end
			S_WALK: begin
				if (walk_done) begin
					state_d = (slot_ok && req_q.req_type == OP_GET_LOCAL) ? S_RDW : S_RESP;
				end else begin
					state_d = link_good ? S_WALKW : S_RESP;
				end
			end
			S_WALKW: state_d = S_WALK;
			S_RDW:   state_d = S_RESP;
			S_ENDW:  state_d = S_RESP;
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory commands and datapath updates
	always_comb begin
		mem_cmd      = '0;
		sp_d         = sp_q;
		fp_d         = fp_q;
		link_d       = link_q;
		cnt_d        = cnt_q;
		res_data_d   = res_data_q;
		res_status_d = res_status_q;
		case (state_q)
			S_EXEC: begin
				res_data_d   = '0;
				res_status_d = ST_OK;
				case (req_q.req_type)
					OP_PUSH: begin
						if (push_full) begin
							res_status_d = ST_OVER;
						end else begin
							mem_cmd.we    = 1'b1;
							mem_cmd.addr  = ADDR_W'(sp_q);
							mem_cmd.wdata = WORD_BITS'(req_q.value);
							sp_d          = sp_q + PTR_W'(1);
						end
					end
					OP_POP, OP_TOP: begin
						if (stack_empty) begin
							res_status_d = ST_UNDER;
						end else begin
							mem_cmd.re   = 1'b1;
							mem_cmd.addr = ADDR_W'(sp_q - PTR_W'(1));
							if (req_q.req_type == OP_POP) begin
								sp_d = sp_q - PTR_W'(1);
							end
						end
					end
					OP_NEW_FRAME: begin
						if (nf_over) begin
							res_status_d = ST_OVER;
						end else begin
							// save the old link, frame starts just above it
							mem_cmd.we    = 1'b1;
							mem_cmd.addr  = ADDR_W'(sp_q);
							mem_cmd.wdata = fp_q;
							sp_d          = sp_q + PTR_W'(1);
							fp_d          = WORD_BITS'(sp_q) + WORD_BITS'(1);
							cnt_d         = CNT_W'(req_q.local_count);
						end
					end
					OP_END_FRAME: begin
						if (!fp_good) begin
							res_status_d = ST_UNDER;
						end else begin
							mem_cmd.re   = 1'b1;
							mem_cmd.addr = ADDR_W'(fp_q - WORD_BITS'(1));
							sp_d         = fp_q[PTR_W-1:0] - PTR_W'(1);
						end
					end
					OP_GET_LOCAL, OP_SET_LOCAL: begin
						if (req_q.var_number == '0) begin
							res_status_d = ST_BAD;
						end else begin
							link_d = fp_q;
							cnt_d  = CNT_W'(req_q.frames_below);
						end
					end
					default: ;
				endcase
			end
			S_FILL: begin
				// one zeroed local per cycle
				mem_cmd.we    = 1'b1;
				mem_cmd.addr  = ADDR_W'(sp_q);
				mem_cmd.wdata = '0;
				sp_d          = sp_q + PTR_W'(1);
				cnt_d         = cnt_q - CNT_W'(1);
			end
			S_WALK: begin
				if (walk_done) begin
					if (!slot_ok) begin
						res_status_d = ST_BAD;
					end else begin
						mem_cmd.addr  = ADDR_W'(slot);
						mem_cmd.wdata = WORD_BITS'(req_q.value);
						if (req_q.req_type == OP_GET_LOCAL) begin
							mem_cmd.re = 1'b1;
						end else begin
							mem_cmd.we = 1'b1;
						end
					end
				end else if (!link_good) begin
					res_status_d = ST_BAD;
				end else begin
					// fetch the saved link below this frame
					mem_cmd.re   = 1'b1;
					mem_cmd.addr = ADDR_W'(link_q - WORD_BITS'(1));
					cnt_d        = cnt_q - CNT_W'(1);
				end
			end
			S_WALKW: link_d = mem_rdata;
			S_RDW:   res_data_d = mem_rdata;
			S_ENDW:  fp_d = mem_rdata;
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			fp_q        <= '1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			fp_q    <= fp_d;
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_word;
		end
		link_q       <= link_d;
		cnt_q        <= cnt_d;
		res_data_q   <= res_data_d;
		res_status_q <= res_status_d;
		if (state_q == S_RESP && out_free) begin
			out_word_q.data   <= res_data_q;
			out_word_q.depth  <= DEPTH_W'(sp_q);
			out_word_q.status <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// fill never runs past the usable capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> (SUM_W'(sp_q) + SUM_W'(cnt_q)) <= cap_eff)
		else $error("frame fill beyond capacity");

	// a read wait state always follows a memory read
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDW || state_q == S_ENDW || state_q == S_WALKW) |-> $past(mem_cmd.re))
		else $error("read data used without a read");

	// stack pointer does not move while waiting for a request
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |=> sp_q == $past(sp_q))
		else $error("stack pointer moved while idle");

	// a new result word comes only from the response state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("result word without a response state");

endmodule

// ===== rtl/frame_linked_call_stack_top.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_word  (req_t)
// out       output     out_valid / out_ready  out_word (rsp_t)
// cfg       input      psel/penable/pwrite    paddr, pwdata, prdata
//
// one request at a time, a single-port stack memory with registered read sets the pace
// push, depth, early rejects: exec, resp; pop, top, end frame, get local: a read wait
// new frame zeroes its locals in turn; get/set local read and wait per frame link
// a finished word waits in the output register and the next request is taken meanwhile
// reset clears pointers and control only, the stack memory is not cleared

module frame_linked_call_stack_top
	import fcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  req_t               in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output rsp_t               out_word,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [CAP_W-1:0]     capacity;
	mem_cmd_t             mem_cmd;
	logic [WORD_BITS-1:0] mem_rdata;

	// configuration registers
	fcs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	// sequencer
	fcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.mem_cmd   (mem_cmd),
		.mem_rdata (mem_rdata)
	);

	// stack memory
	fcs_ram u_ram (
		.clk   (clk),
		.cmd   (mem_cmd),
		.rdata (mem_rdata)
	);

endmodule

// ===== bench/frame_linked_call_stack_top_tb.sv =====
`timescale 1ns / 1ps

module frame_linked_call_stack_top_tb;
	import fcs_pkg::*;

	localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'({REG_CAPACITY, 2'b00});
	localparam logic [WORD_BITS-1:0] NO_LINK = '1;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 300;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	req_t               in_word = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	rsp_t               out_word;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// mirror of the stack, its pointers and the capacity register
	logic [WORD_BITS-1:0] mirror_mem [STACK_DEPTH];
	int                   mirror_sp = 0;
	logic [WORD_BITS-1:0] mirror_fp = NO_LINK;
	logic [CAP_W-1:0]     mirror_cap = CAP_RESET;

	rsp_t owed_results[$];
	int   fail_count = 0;
	int   quiet_cycles = 0;
	bit   calm = 1'b0;

	frame_linked_call_stack_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// a saved link is usable when it points into the live part of the stack
	function automatic bit link_live(input logic [WORD_BITS-1:0] f);
		return (f != NO_LINK) && (f >= 1) && (f <= WORD_BITS'(mirror_sp));
	endfunction

	// follow the frame links down, then index the local from 1
	function automatic bit find_slot(input logic [BELOW_W-1:0] below,
		input logic [VAR_W-1:0] vnum, output int slot);
		logic [WORD_BITS-1:0] f;
		slot = 0;
		if (vnum == 0)
			return 1'b0;
		f = mirror_fp;
		for (int k = 0; k < int'(below); k++) begin
			if (!link_live(f))
				return 1'b0;
			f = mirror_mem[int'(f) - 1];
		end
		if (!link_live(f))
			return 1'b0;
		if (int'(f) + int'(vnum) - 1 >= mirror_sp)
			return 1'b0;
		slot = int'(f) + int'(vnum) - 1;
		return 1'b1;
	endfunction

	// work out the result of one request and move the mirror on
	function automatic rsp_t apply_request(input req_t r);
		rsp_t res;
		int   lim;
		int   slot;
		res = '0;
		res.status = ST_OK;
		lim = (int'(mirror_cap) > STACK_DEPTH) ? STACK_DEPTH : int'(mirror_cap);
		case (r.req_type)
			OP_PUSH: begin
				if (mirror_sp >= lim) begin
					res.status = ST_OVER;
				end else begin
					mirror_mem[mirror_sp] = r.value;
					mirror_sp++;
				end
			end
			OP_POP: begin
				if (mirror_sp == 0) begin
					res.status = ST_UNDER;
				end else begin
					mirror_sp--;
					res.data = mirror_mem[mirror_sp];
				end
			end
			OP_TOP: begin
				if (mirror_sp == 0)
					res.status = ST_UNDER;
				else
					res.data = mirror_mem[mirror_sp - 1];
			end
			OP_NEW_FRAME: begin
				if (mirror_sp + 1 + int'(r.local_count) > lim) begin
					res.status = ST_OVER;
				end else begin
					mirror_mem[mirror_sp] = mirror_fp;
					mirror_sp++;
					mirror_fp = WORD_BITS'(mirror_sp);
					for (int i = 0; i < int'(r.local_count); i++) begin
						mirror_mem[mirror_sp] = '0;
						mirror_sp++;
					end
				end
			end
			OP_END_FRAME: begin
				if (!link_live(mirror_fp)) begin
					res.status = ST_UNDER;
				end else begin
					mirror_sp = int'(mirror_fp) - 1;
					mirror_fp = mirror_mem[mirror_sp];
				end
			end
			OP_GET_LOCAL: begin
				if (find_slot(r.frames_below, r.var_number, slot))
					res.data = mirror_mem[slot];
				else
					res.status = ST_BAD;
			end
			OP_SET_LOCAL: begin
				if (find_slot(r.frames_below, r.var_number, slot))
					mirror_mem[slot] = r.value;
				else
					res.status = ST_BAD;
			end
			default: begin
			end
		endcase
		res.depth = DEPTH_W'(mirror_sp);
		return res;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] want,
		input logic [31:0] got);
		fail_count++;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
	endtask

	// result side back-pressure
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 21);
	end

	// check result words, track register writes and accepted words, watch for a hang
	always @(posedge clk) begin : watch_handshakes
		rsp_t want;
		bit   moved;
		moved = 1'b0;
		if (out_valid && out_ready) begin
			moved = 1'b1;
			if (owed_results.size() == 0) begin
				fail_count++;
				$display("%0t: result word with none expected, expected none, actual %h",
					$time, out_word);
			end else begin
				want = owed_results.pop_front();
				if (out_word.data !== want.data)
					report_mismatch("data", want.data, out_word.data);
				if (out_word.depth !== want.depth)
					report_mismatch("depth", 32'(want.depth), 32'(out_word.depth));
				if (out_word.status !== want.status)
					report_mismatch("status", 32'(want.status), 32'(out_word.status));
			end
		end
		if (psel && penable && pwrite && pready) begin
			moved = 1'b1;
			if (paddr == CAP_ADDR)
				mirror_cap = pwdata[CAP_W-1:0];
		end
		if (in_valid && in_ready) begin
			moved = 1'b1;
			owed_results.push_back(apply_request(in_word));
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d results owed", $time,
				quiet_cycles, owed_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// one request word, with an occasional gap in front of it
	task automatic send_word(input req_t r);
		while (!calm && $urandom_range(0, 99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= r;
		do @(posedge clk); while (!in_ready);
	endtask

	// hold off until every owed result has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAP_ADDR;
		pwdata <= PDATA_W'(cap);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic req_t make_req(input op_t op, input logic [31:0] value = '0,
		input int lc = 0, input int below = 0, input int vnum = 0);
		req_t r;
		r.req_type = op;
		r.value = value;
		r.local_count = LC_W'(lc);
		r.frames_below = BELOW_W'(below);
		r.var_number = VAR_W'(vnum);
		return r;
	endfunction

	// mostly meaningful requests with random content, the rest raw noise
	function automatic req_t random_req();
		req_t r;
		int   pick;
		int   spread;
		r.req_type = op_t'($urandom_range(0, 7));
		r.value = $urandom;
		r.local_count = LC_W'($urandom_range(0, 128));
		r.frames_below = BELOW_W'($urandom);
		r.var_number = VAR_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 92) begin
			if (pick < 20)
				r.req_type = OP_PUSH;
			else if (pick < 30)
				r.req_type = OP_POP;
			else if (pick < 35)
				r.req_type = OP_TOP;
			else if (pick < 48)
				r.req_type = OP_NEW_FRAME;
			else if (pick < 60)
				r.req_type = OP_END_FRAME;
			else if (pick < 75)
				r.req_type = OP_GET_LOCAL;
			else if (pick < 88)
				r.req_type = OP_SET_LOCAL;
			else
				r.req_type = OP_DEPTH;
			// frames stay small apart from the odd large one
			spread = $urandom_range(0, 99);
			if (spread < 90)
				r.local_count = LC_W'($urandom_range(0, 5));
			else if (spread < 98)
				r.local_count = LC_W'($urandom_range(0, 20));
			if ($urandom_range(0, 99) < 85)
				r.frames_below = BELOW_W'($urandom_range(0, 2));
			spread = $urandom_range(0, 99);
			if (spread < 85)
				r.var_number = VAR_W'($urandom_range(1, 6));
			else if (spread < 90)
				r.var_number = '0;
		end
		return r;
	endfunction

	// pop, top, end frame, get local and depth on an empty stack with no frame
	task automatic test_empty_stack();
		send_word(make_req(OP_POP));
		send_word(make_req(OP_TOP));
		send_word(make_req(OP_END_FRAME));
		send_word(make_req(OP_GET_LOCAL, '0, 0, 0, 1));
		send_word(make_req(OP_DEPTH, 32'hDEAD_BEEF));
	endtask

	task automatic test_push_pop();
		send_word(make_req(OP_PUSH, 32'hFFFF_FFFF));
		send_word(make_req(OP_PUSH, 32'h0000_0000));
		send_word(make_req(OP_TOP));
		send_word(make_req(OP_POP));
	endtask

	// nested frames, link walks and bad local numbers
	task automatic test_frames();
		send_word(make_req(OP_NEW_FRAME, '0, 2));
		send_word(make_req(OP_SET_LOCAL, 32'hA5A5_5A5A, 0, 0, 1));
		send_word(make_req(OP_SET_LOCAL, 32'h0F0F_F0F0, 0, 0, 2));
		send_word(make_req(OP_GET_LOCAL, '0, 0, 0, 0));
		send_word(make_req(OP_GET_LOCAL, '0, 0, 0, 3));
		send_word(make_req(OP_NEW_FRAME, '0, 1));
		send_word(make_req(OP_GET_LOCAL, '0, 0, 1, 2));
		send_word(make_req(OP_GET_LOCAL, '0, 0, 2, 1));
		send_word(make_req(OP_GET_LOCAL, '0, 0, 0, 1));
		send_word(make_req(OP_END_FRAME));
		send_word(make_req(OP_END_FRAME));
	endtask

	// capacity of 1 and of the full stack depth, overflow on push and on frame creation
	task automatic test_capacity_limits();
		wait_idle();
		write_capacity(CAP_W'(1));
		send_word(make_req(OP_PUSH, 32'h1234_5678));
		send_word(make_req(OP_PUSH, 32'h8765_4321));
		send_word(make_req(OP_NEW_FRAME, '0, 0));
		send_word(make_req(OP_POP));
		wait_idle();
		write_capacity(CAP_W'(STACK_DEPTH));
		send_word(make_req(OP_NEW_FRAME, '0, 128));
		send_word(make_req(OP_NEW_FRAME, '0, 127));
		send_word(make_req(OP_PUSH, 32'h5555_AAAA));
		send_word(make_req(OP_SET_LOCAL, 32'hC3C3_3C3C, 0, 0, 127));
		send_word(make_req(OP_GET_LOCAL, '0, 0, 0, 127));
		send_word(make_req(OP_GET_LOCAL, '0, 0, 127, 1));
		send_word(make_req(OP_END_FRAME));
	endtask

	// random traffic in phases, capacity changed while drained in between
	task automatic test_random_phases();
		logic [CAP_W-1:0] cap;
		int               n;
		for (int p = 0; p < 6; p++) begin
			wait_idle();
			case (p)
				0: cap = CAP_W'(7);
				1: cap = CAP_W'(STACK_DEPTH);
				2: cap = CAP_W'(1);
				3: cap = CAP_W'(40);
				4: cap = CAP_W'($urandom_range(1, STACK_DEPTH));
				default: cap = CAP_RESET;
			endcase
			write_capacity(cap);
			calm = (p == 3);
			n = (p == 2) ? 120 : 376;
			for (int i = 0; i < n; i++)
				send_word(random_req());
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_stack();
		test_push_pop();
		test_frames();
		test_capacity_limits();
		test_random_phases();
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
